/* rtl/lbd_pkg.sv */
// ----------------------------------------------------------------------------
// Length-prefixed burst deframer package
// State type, operation and status codes and fixed frame layout constants.
// ----------------------------------------------------------------------------
package lbd_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ERR,
      ST_FETCH,
      ST_LOAD
   } state_type;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOB  = 1'b1;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_SHORT    = 2'd1;
   localparam logic [1:0] STAT_MISMATCH = 2'd2;
   localparam logic [1:0] STAT_LONG     = 2'd3;

   localparam int COUNT_W      = 7;
   localparam int COUNT_MAX    = 127;
   localparam int MIN_FRAME    = 5;
   localparam int HEADER_LEN   = 2;
   localparam int PAYLOAD_BASE = 4;

endpackage

/* rtl/length_prefixed_burst_deframer.sv */
// ----------------------------------------------------------------------------
// Length-prefixed burst deframer
// Stores the bytes of one burst, checks the length header at end of burst and
// reads the payload back out one byte per transfer.
// ----------------------------------------------------------------------------
// A received byte is written straight into the frame store while it has room;
// bytes may follow back to back. An end-of-burst transfer closes a non-empty
// frame: a bad frame gives one error transfer through the ERR state, a good
// frame is read out one payload byte at a time, each byte read in FETCH from
// the single read port of the frame store into a read register, then loaded
// into the response register in LOAD once the output slot is free. No new
// transfer is taken during readout. The store needs no clearing after reset.
module length_prefixed_burst_deframer #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_status,
   output logic [15:0] rsp_msg_id,
   output logic [6:0]  rsp_payload_len,
   output logic [5:0]  rsp_byte_index,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last
);

   localparam int STORE_DEPTH = MAX_PAYLOAD + lbd_pkg::PAYLOAD_BASE;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int CW          = lbd_pkg::COUNT_W;

   logic [7:0] frame_store [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   lbd_pkg::state_type state_ff, state_in;

   logic [CW-1:0] byte_count_ff;
   logic [15:0]   len_ff;
   logic [15:0]   id_ff;
   logic [1:0]    status_ff;
   logic [CW-1:0] plen_ff;
   logic [5:0]    idx_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [15:0]   rsp_id_ff;
   logic [6:0]    rsp_plen_ff;
   logic [5:0]    rsp_idx_ff;
   logic [7:0]    rsp_data_ff;
   logic          rsp_last_ff;

   logic          req_fire;
   logic          byte_fire;
   logic          eob_fire;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [CW-1:0] rd_pos;
   logic [AW-1:0] rd_addr;
   logic          slot_free;
   logic          is_last;
   logic          load_err;
   logic          load_data;
   logic [1:0]    status_in;
   logic [CW-1:0] plen_in;

   assign req_fire  = req_valid && req_ready;
   assign byte_fire = req_fire && (req_operation == lbd_pkg::OP_BYTE);
   assign eob_fire  = req_fire && (req_operation == lbd_pkg::OP_EOB);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_last   = (CW'(idx_ff) + CW'(1)) == plen_ff;

   assign wr_en   = byte_fire && (byte_count_ff < CW'(STORE_DEPTH));
   assign wr_addr = byte_count_ff[AW-1:0];
   assign rd_pos  = CW'(idx_ff) + CW'(lbd_pkg::PAYLOAD_BASE);
   assign rd_addr = rd_pos[AW-1:0];

   // Frame checks at end of burst
   always_comb begin
      plen_in = byte_count_ff - CW'(lbd_pkg::PAYLOAD_BASE);
      if (byte_count_ff < CW'(lbd_pkg::MIN_FRAME)) begin
         status_in = lbd_pkg::STAT_SHORT;
      end else if (len_ff != (16'(byte_count_ff) - 16'(lbd_pkg::HEADER_LEN))) begin
         status_in = lbd_pkg::STAT_MISMATCH;
      end else if (plen_in > CW'(MAX_PAYLOAD)) begin
         status_in = lbd_pkg::STAT_LONG;
      end else begin
         status_in = lbd_pkg::STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_store[wr_addr] <= req_rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= frame_store[rd_addr];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbd_pkg::ST_IDLE: begin
            if (eob_fire && (byte_count_ff != '0)) begin
               state_in = (status_in == lbd_pkg::STAT_OK) ? lbd_pkg::ST_FETCH
                                                          : lbd_pkg::ST_ERR;
            end
         end
         lbd_pkg::ST_ERR: begin
            if (slot_free) begin
               state_in = lbd_pkg::ST_IDLE;
            end
         end
         lbd_pkg::ST_FETCH: begin
            state_in = lbd_pkg::ST_LOAD;
         end
         lbd_pkg::ST_LOAD: begin
            if (slot_free) begin
               state_in = is_last ? lbd_pkg::ST_IDLE : lbd_pkg::ST_FETCH;
            end
         end
         default: state_in = lbd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      load_err  = 1'b0;
      load_data = 1'b0;
      unique case (state_ff)
         lbd_pkg::ST_IDLE:  req_ready = 1'b1;
         lbd_pkg::ST_ERR:   load_err  = slot_free;
         lbd_pkg::ST_FETCH: rd_en     = 1'b1;
         lbd_pkg::ST_LOAD:  load_data = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lbd_pkg::ST_IDLE;
         byte_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (eob_fire) begin
            byte_count_ff <= '0;
         end else if (byte_fire && (byte_count_ff < CW'(lbd_pkg::COUNT_MAX))) begin
            byte_count_ff <= byte_count_ff + CW'(1);
         end
         if (load_err || load_data) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (byte_fire) begin
         case (byte_count_ff)
            CW'(0):  len_ff[15:8] <= req_rx_byte;
            CW'(1):  len_ff[7:0]  <= req_rx_byte;
            CW'(2):  id_ff[15:8]  <= req_rx_byte;
            CW'(3):  id_ff[7:0]   <= req_rx_byte;
            default: ;
         endcase
      end
      if (eob_fire) begin
         status_ff <= status_in;
         plen_ff   <= plen_in;
         idx_ff    <= '0;
      end else if (load_data && !is_last) begin
         idx_ff <= idx_ff + 6'd1;
      end
      if (load_err) begin
         rsp_status_ff <= status_ff;
         rsp_id_ff     <= '0;
         rsp_plen_ff   <= '0;
         rsp_idx_ff    <= '0;
         rsp_data_ff   <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (load_data) begin
         rsp_status_ff <= lbd_pkg::STAT_OK;
         rsp_id_ff     <= id_ff;
         rsp_plen_ff   <= plen_ff;
         rsp_idx_ff    <= idx_ff;
         rsp_data_ff   <= rd_data_ff;
         rsp_last_ff   <= is_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_msg_id       = rsp_id_ff;
   assign rsp_payload_len  = rsp_plen_ff;
   assign rsp_byte_index   = rsp_idx_ff;
   assign rsp_data_byte    = rsp_data_ff;
   assign rsp_last         = rsp_last_ff;

   a_close_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (eob_fire && (byte_count_ff != '0)) |=> !req_ready)
      else $error("input still open after a non-empty frame closed");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != lbd_pkg::STAT_OK)) |-> rsp_last_ff)
      else $error("error transfer without last");

   a_read_in_payload: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbd_pkg::ST_FETCH) |-> (CW'(idx_ff) < plen_ff))
      else $error("payload read beyond frame length");

endmodule
